// File: rtl/e2r_pkg.sv
// ============================================================================
// e2r_pkg: shared constants, types and functions for the Euler angle to
// rotation matrix block.
// ============================================================================
package e2r_pkg;

    localparam int ANGLE_BITS_DEF    = 16;
    localparam int FRAC_BITS_DEF     = 14;
    localparam int CORDIC_STAGES_DEF = 16;
    localparam int OUT_BITS          = 16;

    // CORDIC datapath width: Q30 values plus guard bits.
    localparam int CW = 34;
    // Phase accumulator width.
    localparam int ZW = 33;

    localparam logic signed [CW-1:0] CORDIC_GAIN_Q30 = 34'sd652032874;

    // Arctangent of 2^-i in units of 2^-32 turn.
    function automatic logic signed [ZW-1:0] atan_step(input int i);
        logic [31:0] t;
        begin
            t = 32'h0;
            case (i)
                0:  t = 32'h20000000; 1:  t = 32'h12E4051E;
                2:  t = 32'h09FB385B; 3:  t = 32'h051111D4;
                4:  t = 32'h028B0D43; 5:  t = 32'h0145D7E1;
                6:  t = 32'h00A2F61E; 7:  t = 32'h00517C55;
                8:  t = 32'h0028BE53; 9:  t = 32'h00145F2F;
                10: t = 32'h000A2F98; 11: t = 32'h000517CC;
                12: t = 32'h00028BE6; 13: t = 32'h000145F3;
                14: t = 32'h0000A2FA; 15: t = 32'h0000517D;
                16: t = 32'h000028BE; 17: t = 32'h0000145F;
                18: t = 32'h00000A30; 19: t = 32'h00000518;
                20: t = 32'h0000028C; 21: t = 32'h00000146;
                22: t = 32'h000000A3; 23: t = 32'h00000051;
                24: t = 32'h00000029; 25: t = 32'h00000014;
                26: t = 32'h0000000A; 27: t = 32'h00000005;
                28: t = 32'h00000003; 29: t = 32'h00000001;
                30: t = 32'h00000001;
                default: t = 32'h0;
            endcase
            atan_step = $signed({1'b0, t});
        end
    endfunction

    // One angle on its way through the rotator chain.
    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [ZW-1:0] z;
        logic [1:0]           q;
    } t_rot;

endpackage

// File: rtl/euler_to_rotation_matrix_top.sv
// ============================================================================
// euler_to_rotation_matrix_top: heading/pitch/bank to 3x3 rotation matrix.
// A chain of CORDIC cells forms sine and cosine; a multiplier pipeline
// forms the nine Q1.14 entries.
// ============================================================================
//  channel | signals                           | direction
//  input   | i_valid, o_stall, i_heading/pitch/bank | in
//  output  | o_valid, i_stall, o_m00 .. o_m22  | out
//
// One item is accepted every cycle while o_stall is low. Data passes the phase
// setup register, the CORDIC cell chain and the multiplier stages.
// Each stage advances when the stage after it is empty or moving; a stall at
// the output holds the full stages behind it, and o_stall follows once a full first stage is held.
// Reset clears only the valid bits of the pipeline.
module euler_to_rotation_matrix_top #(
    parameter int ANGLE_BITS    = e2r_pkg::ANGLE_BITS_DEF,
    parameter int FRAC_BITS     = e2r_pkg::FRAC_BITS_DEF,
    parameter int CORDIC_STAGES = e2r_pkg::CORDIC_STAGES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [15:0] i_heading,
    input  logic [15:0] i_pitch,
    input  logic [15:0] i_bank,
    output logic        o_valid,
    input  logic        i_stall,
    output logic signed [15:0] o_m00, o_m01, o_m02,
    output logic signed [15:0] o_m10, o_m11, o_m12,
    output logic signed [15:0] o_m20, o_m21, o_m22
);
    import e2r_pkg::*;

    localparam int DEPTH = CORDIC_STAGES + 5;

    logic [DEPTH-1:0] r_vld;
    logic [DEPTH-1:0] n_vld;
    logic [DEPTH-1:0] w_en;

    // Each stage moves when the stage after it is empty or moving.
    always_comb begin
        w_en[DEPTH-1] = !r_vld[DEPTH-1] || !i_stall;
        for (int k = DEPTH - 2; k >= 0; k--) begin
            w_en[k] = !r_vld[k] || w_en[k+1];
        end
    end
    assign o_stall = !w_en[0] && r_vld[0];

    always_comb begin
        for (int k = 0; k < DEPTH; k++) begin
            if (k == 0) n_vld[k] = w_en[0] ? i_valid : r_vld[0];
            else        n_vld[k] = w_en[k] ? r_vld[k-1] : r_vld[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    // Phase setup: quadrant split and residual.
    t_rot r_in [3];
    logic [15:0] w_ang [3];
    assign w_ang[0] = i_heading;
    assign w_ang[1] = i_pitch;
    assign w_ang[2] = i_bank;

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            for (int a = 0; a < 3; a++) begin
                logic [31:0] ph;
                logic [1:0]  q;
                logic [31:0] rr;
                ph = 32'(w_ang[a][ANGLE_BITS-1:0]) << (32 - ANGLE_BITS);
                q  = 2'((ph + 32'h20000000) >> 30);
                rr = ph - ({30'd0, q} << 30);
                r_in[a].q <= q;
                r_in[a].x <= CORDIC_GAIN_Q30;
                r_in[a].y <= '0;
                r_in[a].z <= $signed({rr[31], rr});
            end
        end
    end

    // Chain of rotation cells.
    t_rot w_chain [CORDIC_STAGES+1][3];
    assign w_chain[0] = r_in;

    for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cell
        e2r_cordic_cell #(.STAGE(g)) u_cell (
            .i_clk (i_clk),
            .i_en  (w_en[g+1]),
            .i_rot (w_chain[g]),
            .o_rot (w_chain[g+1])
        );
    end

    logic signed [OUT_BITS-1:0] w_m [9];
    e2r_matrix #(.FRAC_BITS(FRAC_BITS)) u_matrix (
        .i_clk (i_clk),
        .i_en  (w_en[DEPTH-1:DEPTH-4]),
        .i_rot (w_chain[CORDIC_STAGES]),
        .o_m   (w_m)
    );

    assign o_valid = r_vld[DEPTH-1];
    assign o_m00 = w_m[0];
    assign o_m01 = w_m[1];
    assign o_m02 = w_m[2];
    assign o_m10 = w_m[3];
    assign o_m11 = w_m[4];
    assign o_m12 = w_m[5];
    assign o_m20 = w_m[6];
    assign o_m21 = w_m[7];
    assign o_m22 = w_m[8];
endmodule

// File: rtl/e2r_cordic_cell.sv
// ============================================================================
// e2r_cordic_cell: one registered CORDIC rotation step for three angles.
// Each cell takes the vectors from its left neighbor and hands them right.
// ============================================================================
module e2r_cordic_cell #(
    parameter int STAGE = 0
) (
    input  logic              i_clk,
    input  logic              i_en,
    input  e2r_pkg::t_rot     i_rot [3],
    output e2r_pkg::t_rot     o_rot [3]
);
    import e2r_pkg::*;

    localparam int K = (STAGE < 32) ? STAGE : 31;
    localparam logic signed [ZW-1:0] STEP = atan_step(STAGE);

    t_rot r_rot [3];
    t_rot n_rot [3];

    // Rotate each vector toward the residual angle.
    always_comb begin
        for (int a = 0; a < 3; a++) begin
            n_rot[a].q = i_rot[a].q;
            if (!i_rot[a].z[ZW-1]) begin
                n_rot[a].x = i_rot[a].x - (i_rot[a].y >>> K);
                n_rot[a].y = i_rot[a].y + (i_rot[a].x >>> K);
                n_rot[a].z = i_rot[a].z - STEP;
            end else begin
                n_rot[a].x = i_rot[a].x + (i_rot[a].y >>> K);
                n_rot[a].y = i_rot[a].y - (i_rot[a].x >>> K);
                n_rot[a].z = i_rot[a].z + STEP;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rot <= n_rot;
        end
    end

    assign o_rot = r_rot;
endmodule

// File: rtl/e2r_matrix.sv
// ============================================================================
// e2r_matrix: turns the rotator outputs into sine and cosine values and
// forms the nine matrix entries over a short pipeline of multipliers.
// ============================================================================
module e2r_matrix #(
    parameter int FRAC_BITS = e2r_pkg::FRAC_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic [3:0]                          i_en,
    input  e2r_pkg::t_rot                       i_rot [3],
    output logic signed [e2r_pkg::OUT_BITS-1:0] o_m [9]
);
    import e2r_pkg::*;

    localparam int SW = FRAC_BITS + 2;     // holds +-2^FRAC_BITS
    localparam int PW = 2 * SW;
    localparam int SH = 30 - FRAC_BITS;
    localparam logic signed [SW-1:0] ONE  = SW'(1) <<< FRAC_BITS;
    localparam logic signed [SW-1:0] MONE = -ONE;

    // Saturate a wide value to +-2^FRAC_BITS.
    function automatic logic signed [SW-1:0] sat(input logic signed [PW+1:0] v);
        begin
            if (v > PW'(ONE) + (PW+2)'(0))      sat = ONE;
            else if (v < (PW+2)'(MONE))         sat = MONE;
            else                                sat = SW'(v);
        end
    endfunction

    // Rounded fixed-point product.
    function automatic logic signed [PW+1:0] mulq(input logic signed [SW-1:0] a,
                                                  input logic signed [SW-1:0] b);
        logic signed [PW+1:0] p;
        begin
            p = (PW+2)'(a) * (PW+2)'(b) + ((PW+2)'(1) <<< (FRAC_BITS - 1));
            mulq = p >>> FRAC_BITS;
        end
    endfunction

    // Scaling down from Q30 with rounding, then saturation to +-2^FRAC_BITS.
    function automatic logic signed [SW-1:0] scl(input logic signed [CW-1:0] v);
        logic signed [CW:0] t;
        begin
            if (SH == 0) t = {v[CW-1], v};
            else         t = ($signed({v[CW-1], v})
                              + ((CW+1)'(1) <<< (SH > 0 ? SH - 1 : 0))) >>> SH;
            if (t > (CW+1)'(ONE))       scl = ONE;
            else if (t < (CW+1)'(MONE)) scl = MONE;
            else                        scl = SW'(t);
        end
    endfunction

    logic signed [SW-1:0] r_s [3];
    logic signed [SW-1:0] r_c [3];
    logic signed [CW-1:0] n_cc [3];
    logic signed [CW-1:0] n_ss [3];

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            unique case (i_rot[a].q)
                2'd0: begin n_cc[a] = i_rot[a].x;  n_ss[a] = i_rot[a].y;  end
                2'd1: begin n_cc[a] = -i_rot[a].y; n_ss[a] = i_rot[a].x;  end
                2'd2: begin n_cc[a] = -i_rot[a].x; n_ss[a] = -i_rot[a].y; end
                default: begin n_cc[a] = i_rot[a].y; n_ss[a] = -i_rot[a].x; end
            endcase
        end
    end

    // Stage 1: sine and cosine of heading (0), pitch (1), bank (2).
    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            for (int a = 0; a < 3; a++) begin
                r_s[a] <= scl(n_ss[a]);
                r_c[a] <= scl(n_cc[a]);
            end
        end
    end

    // Stage 2: first-level products.
    logic signed [SW-1:0] r_cbch, r_spsh, r_spch, r_sbcp, r_cbcp, r_cpsh, r_cpch;
    logic signed [SW-1:0] r_cbsh, r_sbch, r_sbsh, r_msp;
    logic signed [SW-1:0] r_sb2, r_cb2, r_sp2;
    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r_cbch <= SW'(mulq(r_c[2], r_c[0]));
            r_spsh <= SW'(mulq(r_s[1], r_s[0]));
            r_spch <= SW'(mulq(r_s[1], r_c[0]));
            r_sbcp <= sat(mulq(r_s[2], r_c[1]));
            r_cbcp <= sat(mulq(r_c[2], r_c[1]));
            r_cpsh <= sat(mulq(r_c[1], r_s[0]));
            r_cpch <= sat(mulq(r_c[1], r_c[0]));
            r_cbsh <= SW'(mulq(r_c[2], r_s[0]));
            r_sbch <= SW'(mulq(r_s[2], r_c[0]));
            r_sbsh <= SW'(mulq(r_s[2], r_s[0]));
            r_msp  <= sat(-(PW+2)'(r_s[1]));
            r_sb2  <= r_s[2];
            r_cb2  <= r_c[2];
            r_sp2  <= r_s[1];
        end
    end

    // Stage 3: second-level products and sums.
    logic signed [SW-1:0] r_m [9];
    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            r_m[0] <= sat((PW+2)'(r_cbch) + mulq(r_sb2, r_spsh));
            r_m[1] <= r_sbcp;
            r_m[2] <= sat(-(PW+2)'(r_cbsh) + mulq(r_sb2, r_spch));
            r_m[3] <= sat(-(PW+2)'(r_sbch) + mulq(r_cb2, r_spsh));
            r_m[4] <= r_cbcp;
            r_m[5] <= sat((PW+2)'(r_sbsh) + mulq(r_sp2, r_cbch));
            r_m[6] <= r_cpsh;
            r_m[7] <= r_msp;
            r_m[8] <= r_cpch;
        end
    end

    // Output register holds the result while the receiver stalls.
    always_ff @(posedge i_clk) begin
        if (i_en[3]) begin
            for (int k = 0; k < 9; k++) begin
                o_m[k] <= OUT_BITS'(r_m[k]);
            end
        end
    end
endmodule

// File: bench/euler_to_rotation_matrix_top_tb.sv
// ----------------------------------------------------------------------------
// Euler angle to rotation matrix testbench
// Drives heading, pitch and bank angles through the valid/stall channel,
// predicts each matrix with a bit-exact CORDIC and product model, and checks
// every output transfer against the oldest prediction in order.
// ----------------------------------------------------------------------------
module euler_to_rotation_matrix_top_tb;

    localparam int ANGLE_BITS = 16;
    localparam int FRAC_BITS  = 14;
    localparam int STAGES     = 16;
    localparam int LATENCY    = STAGES + 5;
    localparam int N_RANDOM   = 1600;
    localparam int CYCLE_LIMIT = 400000;
    localparam longint ONE_Q  = 64'sd1 << FRAC_BITS;

    typedef struct packed {
        logic [15:0] heading;
        logic [15:0] pitch;
        logic [15:0] bank;
    } t_angles;

    typedef struct packed {
        logic [15:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;
    } t_matrix;

    // Directed row: angles and, where obvious, the expected matrix.
    typedef struct {
        t_angles angles;
        bit      typed;
        t_matrix matrix;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [15:0] i_heading = '0, i_pitch = '0, i_bank = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic signed [15:0] o_m00, o_m01, o_m02, o_m10, o_m11, o_m12, o_m20, o_m21, o_m22;

    t_matrix pending_matrices[$];
    int      mismatch_count = 0;
    int      matrices_checked = 0;
    longint  cycle_count = 0;
    bit      stall_mode = 1'b0;

    euler_to_rotation_matrix_top dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_heading(i_heading), .i_pitch(i_pitch), .i_bank(i_bank),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_m00(o_m00), .o_m01(o_m01), .o_m02(o_m02),
        .o_m10(o_m10), .o_m11(o_m11), .o_m12(o_m12),
        .o_m20(o_m20), .o_m21(o_m21), .o_m22(o_m22)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Rotation table, one entry per CORDIC stage, in 2^-32 turn units.
    function automatic longint atan_turn(input int i);
        longint t [0:31];
        t = '{64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4,
              64'h028B0D43, 64'h0145D7E1, 64'h00A2F61E, 64'h00517C55,
              64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
              64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D,
              64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
              64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051,
              64'h00000029, 64'h00000014, 64'h0000000A, 64'h00000005,
              64'h00000003, 64'h00000001, 64'h00000001, 64'h00000000};
        return (i < 32) ? t[i] : 64'sd0;
    endfunction

    function automatic longint clamp_unit(input longint v);
        if (v > ONE_Q) return ONE_Q;
        if (v < -ONE_Q) return -ONE_Q;
        return v;
    endfunction

    // Q30 to Q(FRAC_BITS) with round half up, then saturation.
    function automatic longint reduce_q30(input longint v);
        longint s;
        s = 30 - FRAC_BITS;
        return clamp_unit((v + (64'sd1 << (s - 1))) >>> s);
    endfunction

    function automatic longint qmul(input longint a, input longint b);
        return (a * b + (64'sd1 << (FRAC_BITS - 1))) >>> FRAC_BITS;
    endfunction

    // Sine and cosine of a binary angle through the quadrant fold and CORDIC.
    task automatic angle_sin_cos(input logic [15:0] angle, output longint sn,
                                 output longint cs);
        logic [31:0] phase, resid;
        logic [1:0]  quad;
        longint x, y, z, nx, dx, dy;
        phase = 32'(angle) << (32 - ANGLE_BITS);
        quad  = 2'((phase + 32'h20000000) >> 30);
        resid = phase - {quad, 30'h0};
        z = longint'($signed(resid));
        x = 64'sd652032874;
        y = 0;
        for (int i = 0; i < STAGES; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                nx = x - dx; y = y + dy; z = z - atan_turn(i);
            end else begin
                nx = x + dx; y = y - dy; z = z + atan_turn(i);
            end
            x = nx;
        end
        case (quad)
            2'd0: begin cs = x;  sn = y;  end
            2'd1: begin cs = -y; sn = x;  end
            2'd2: begin cs = -x; sn = -y; end
            default: begin cs = y; sn = -x; end
        endcase
        sn = reduce_q30(sn);
        cs = reduce_q30(cs);
    endtask

    function automatic logic [15:0] entry(input longint v);
        return 16'(clamp_unit(v));
    endfunction

    // Rotation matrix predicted for one set of angles.
    task automatic predict_matrix(input t_angles a, output t_matrix m);
        longint sh, ch, sp, cp, sb, cb, cbch, spsh, spch;
        angle_sin_cos(a.heading, sh, ch);
        angle_sin_cos(a.pitch, sp, cp);
        angle_sin_cos(a.bank, sb, cb);
        cbch = qmul(cb, ch);
        spsh = qmul(sp, sh);
        spch = qmul(sp, ch);
        m.m00 = entry(cbch + qmul(sb, spsh));
        m.m01 = entry(qmul(sb, cp));
        m.m02 = entry(-qmul(cb, sh) + qmul(sb, spch));
        m.m10 = entry(-qmul(sb, ch) + qmul(cb, spsh));
        m.m11 = entry(qmul(cb, cp));
        m.m12 = entry(qmul(sb, sh) + qmul(sp, cbch));
        m.m20 = entry(qmul(cp, sh));
        m.m21 = entry(-sp);
        m.m22 = entry(qmul(cp, ch));
    endtask

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        $display("mismatch %s: got %0d expected %0d at cycle %0d",
                 what, $signed(got), $signed(want), cycle_count);
        mismatch_count++;
    endtask

    // Receiver: pattern of stalls, checking each output transfer.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (i_rst_n && o_valid && !i_stall) begin
            t_matrix got, want;
            got = {o_m00, o_m01, o_m02, o_m10, o_m11, o_m12, o_m20, o_m21, o_m22};
            if (pending_matrices.size() == 0) begin
                report_mismatch("unexpected matrix", got.m00, 16'h0);
            end else begin
                want = pending_matrices.pop_front();
                matrices_checked++;
                if (got.m00 !== want.m00) report_mismatch("m00", got.m00, want.m00);
                if (got.m01 !== want.m01) report_mismatch("m01", got.m01, want.m01);
                if (got.m02 !== want.m02) report_mismatch("m02", got.m02, want.m02);
                if (got.m10 !== want.m10) report_mismatch("m10", got.m10, want.m10);
                if (got.m11 !== want.m11) report_mismatch("m11", got.m11, want.m11);
                if (got.m12 !== want.m12) report_mismatch("m12", got.m12, want.m12);
                if (got.m20 !== want.m20) report_mismatch("m20", got.m20, want.m20);
                if (got.m21 !== want.m21) report_mismatch("m21", got.m21, want.m21);
                if (got.m22 !== want.m22) report_mismatch("m22", got.m22, want.m22);
            end
        end
        // Alternate between calm stretches and heavy stalling.
        if (cycle_count[7:0] == 8'hFF) stall_mode <= ~stall_mode;
        if (!stall_mode) i_stall <= 1'b0;
        else i_stall <= ($urandom_range(0, 99) < 40);
    end

    // Present one set of angles and hold it until the transfer happens.
    task automatic send_angles(input t_angles a);
        t_matrix m;
        predict_matrix(a, m);
        i_valid   <= 1'b1;
        i_heading <= a.heading;
        i_pitch   <= a.pitch;
        i_bank    <= a.bank;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        pending_matrices.push_back(m);
    endtask

    task automatic idle_cycles(input int n);
        i_valid <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    // Cycle limit guard.
    always @(posedge i_clk) begin
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial begin
        t_row    rows[$];
        t_row    r;
        t_matrix got_pred;
        t_angles a;
        int      burst;
        // Identity, quarter turns and other single-axis angles, all-ones angles, one mixed set.
        r.typed = 1'b1;
        r.angles = '{16'h0000, 16'h0000, 16'h0000};
        r.matrix = '{16'sd16384, 16'sd0, 16'sd0, 16'sd0, 16'sd16384, 16'sd0,
                     16'sd0, 16'sd0, 16'sd16384};
        rows.push_back(r);
        r.typed = 1'b0;
        for (int k = 0; k < 8; k++) begin
            logic [15:0] v;
            case (k)
                0: v = 16'h4000; 1: v = 16'h8000; 2: v = 16'hC000; 3: v = 16'hFFFF;
                4: v = 16'h2000; 5: v = 16'h0001; 6: v = 16'h7FFF; default: v = 16'hE000;
            endcase
            r.angles = '{v, 16'h0, 16'h0}; rows.push_back(r);
            r.angles = '{16'h0, v, 16'h0}; rows.push_back(r);
            if (k < 6) begin r.angles = '{16'h0, 16'h0, v}; rows.push_back(r); end
        end
        r.angles = '{16'hFFFF, 16'hFFFF, 16'hFFFF}; rows.push_back(r);
        r.angles = '{16'hAAAA, 16'h5555, 16'h1FFF}; rows.push_back(r);

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table; typed rows are checked against the predictor too.
        foreach (rows[i]) begin
            if (rows[i].typed) begin
                predict_matrix(rows[i].angles, got_pred);
                if (got_pred !== rows[i].matrix)
                    report_mismatch("identity prediction", got_pred.m00, rows[i].matrix.m00);
            end
            send_angles(rows[i].angles);
        end

        // Pause until the pipeline has drained completely.
        i_valid <= 1'b0;
        while (pending_matrices.size() != 0) @(posedge i_clk);

        // Random bursts with random gaps; some angles near quadrant edges.
        for (int n = 0; n < N_RANDOM; ) begin
            burst = $urandom_range(1, 40);
            for (int b = 0; b < burst && n < N_RANDOM; b++, n++) begin
                a = {16'($urandom), 16'($urandom), 16'($urandom)};
                if ($urandom_range(0, 7) == 0)
                    a.pitch = {$urandom_range(0, 3) == 0 ? 2'b00 : 2'($urandom),
                               14'h1FFF + 14'($urandom_range(0, 2))};
                send_angles(a);
            end
            if ($urandom_range(0, 2) != 0) idle_cycles($urandom_range(1, 30));
        end
        i_valid <= 1'b0;

        while (pending_matrices.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);

        $display("checked %0d matrices from directed extremes and random angles",
                 matrices_checked);
        if (mismatch_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

// File: files.f
rtl/e2r_pkg.sv
rtl/e2r_cordic_cell.sv
rtl/e2r_matrix.sv
rtl/euler_to_rotation_matrix_top.sv
bench/euler_to_rotation_matrix_top_tb.sv
